@@ hw/rtl/hprf_pkg.sv @@
// package for the heading pid controller with rate feedback
// holds widths, fixed-point constants, control-word types and the microcode table
// no dependencies
package hprf_pkg;

   // error integral width and the widths that follow from it
   localparam int INTEGRAL_WIDTH = 24;
   localparam int INT_EXT_W      = INTEGRAL_WIDTH + 1;
   localparam int PID_W          = (INTEGRAL_WIDTH + 10 > 34) ? INTEGRAL_WIDTH + 10 : 34;
   localparam int TOT_W          = PID_W + 12;
   localparam int MA_W           = PID_W;
   localparam int MB_W           = 15;
   localparam int MP_W           = MA_W + MB_W + 1;
   localparam int SPD_W          = 28;

   // sequencer
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_ERR   = 3'd0;
   localparam logic [STEP_W-1:0] STEP_SPDY  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_PROP  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_DERIV = 3'd3;
   localparam logic [STEP_W-1:0] STEP_INTEG = 3'd4;
   localparam logic [STEP_W-1:0] STEP_SCALE = 3'd5;
   localparam logic [STEP_W-1:0] STEP_RATE  = 3'd6;
   localparam logic [STEP_W-1:0] STEP_OUT   = 3'd7;

   // angle handling, 1/64 degree
   localparam logic signed [15:0] ERR_HALF_TURN = 16'sd11520;
   localparam logic signed [15:0] ERR_NEG_HALF  = -16'sd11520;
   localparam logic signed [15:0] ERR_FULL_TURN = 16'sd23040;
   localparam logic [13:0]        INT_LOW_MIN   = 14'd7;
   localparam logic [13:0]        INT_HIGH_LIM  = 14'd320;
   localparam logic [13:0]        WIDE_ERR      = 14'd1280;
   localparam logic [SPD_W-1:0]   SLOW_SPEED_SQ = 28'd40000;

   // output limits at 2^-17 of an output unit
   localparam logic signed [31:0] LIM_MAIN_SC = 32'sd1971322880;
   localparam logic signed [31:0] LIM_WIDE_SC = 32'sd629145600;
   localparam logic signed [31:0] LIM_SLOW_SC = 32'sd251658240;
   localparam logic signed [31:0] ROUND_HALF  = 32'sd65536;

   // csr defaults and indexes
   localparam logic [7:0] IGAIN_RESET = 8'd38;
   typedef enum logic [2:0] {
      CSR_IGAIN   = 3'd0,
      CSR_RFGAIN  = 3'd1,
      CSR_INT_EN  = 3'd2,
      CSR_WIDE_EN = 3'd3,
      CSR_SLOW_EN = 3'd4
   } csr_idx_type;

   typedef enum logic [2:0] {
      A_ERR, A_DSUM, A_INT, A_PID, A_RATE, A_SPDX, A_SPDY
   } a_sel_type;

   typedef enum logic [2:0] {
      B_KP2, B_KD, B_KI2, B_GSC, B_GAIN, B_SPDX, B_SPDY
   } b_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB_SH9
   } acc_op_type;

   typedef enum logic [1:0] {
      SPD_HOLD, SPD_LOAD, SPD_ADD
   } spd_op_type;

   typedef enum logic [1:0] {
      JMP_NEXT, JMP_IF_INT_ZERO, JMP_END
   } jmp_type;

   typedef enum logic {
      SEQ_IDLE, SEQ_RUN
   } seq_state_type;

   typedef struct packed {
      a_sel_type          a_sel;
      b_sel_type          b_sel;
      acc_op_type         acc_op;
      spd_op_type         spd_op;
      logic               err_en;
      logic               out_en;
      jmp_type            jmp;
      logic [STEP_W-1:0]  target;
   } ucode_type;

   // microprogram: one control word per step
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type uw;
      uw = '{A_ERR, B_KP2, ACC_HOLD, SPD_HOLD, 1'b0, 1'b0, JMP_NEXT, STEP_ERR};
      case (step)
         STEP_ERR: begin
            uw = '{A_SPDX, B_SPDX, ACC_HOLD, SPD_LOAD, 1'b1, 1'b0, JMP_NEXT, STEP_ERR};
         end
         STEP_SPDY: begin
            uw = '{A_SPDY, B_SPDY, ACC_HOLD, SPD_ADD, 1'b0, 1'b0, JMP_NEXT, STEP_ERR};
         end
         STEP_PROP: begin
            uw = '{A_ERR, B_KP2, ACC_LOAD, SPD_HOLD, 1'b0, 1'b0, JMP_NEXT, STEP_ERR};
         end
         // integral term skipped when the sum is zero
         STEP_DERIV: begin
            uw = '{A_DSUM, B_KD, ACC_ADD, SPD_HOLD, 1'b0, 1'b0, JMP_IF_INT_ZERO,
                   STEP_SCALE};
         end
         STEP_INTEG: begin
            uw = '{A_INT, B_KI2, ACC_ADD, SPD_HOLD, 1'b0, 1'b0, JMP_NEXT, STEP_ERR};
         end
         STEP_SCALE: begin
            uw = '{A_PID, B_GSC, ACC_LOAD, SPD_HOLD, 1'b0, 1'b0, JMP_NEXT, STEP_ERR};
         end
         STEP_RATE: begin
            uw = '{A_RATE, B_GAIN, ACC_SUB_SH9, SPD_HOLD, 1'b0, 1'b0, JMP_NEXT, STEP_ERR};
         end
         STEP_OUT: begin
            uw = '{A_ERR, B_KP2, ACC_HOLD, SPD_HOLD, 1'b0, 1'b1, JMP_END, STEP_ERR};
         end
         default: begin
            uw = '{A_ERR, B_KP2, ACC_HOLD, SPD_HOLD, 1'b0, 1'b0, JMP_END, STEP_ERR};
         end
      endcase
      return uw;
   endfunction

endpackage

@@ hw/rtl/heading_pid_with_rate_feedback.sv @@
// heading pid controller with rate feedback: microcoded sequencer and datapath
// depends on hprf_pkg for widths, constants and the microcode table
//
// usage: the req channel carries one control tick (headings, p and d gains,
// yaw rate, planar speed); the rsp channel returns one clamped rate command.
// a transfer happens on a rising edge with valid high and stall low.
// each tick runs through an eight-step microprogram on one shared multiplier
// and two accumulators: error wrap and integral update, two speed squares,
// the three pid products, rate-feedback scaling, then clamp and round.
// the integral product step is skipped when the integral is zero.
// the result is registered at the end of the output step, and the next
// request is taken in the cycle the result is loaded, so a waiting
// result does not hold off the next tick; when the result register is still
// full and rsp_stall is high, the last step waits and req_stall stays high.
// reset clears the controller history (previous error, previous difference,
// integral), the sequencer and rsp_valid, and loads the register defaults.
// the user must write registers over the apb port only while no tick is in
// flight; the block itself does not enforce this.
module heading_pid_with_rate_feedback
   import hprf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [14:0] req_measured_angle,
   input  logic signed [14:0] req_target_angle,
   input  logic [13:0]        req_prop_gain,
   input  logic [14:0]        req_deriv_gain,
   input  logic signed [16:0] req_measured_rate,
   input  logic signed [13:0] req_speed_x,
   input  logic signed [13:0] req_speed_y,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [14:0] rsp_rate_command,
   // register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // sequencer
   seq_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   ucode_type         uc;
   logic              req_accept, out_free, run, load_out;

   // registers
   logic [7:0] igain_ff, igain_in;
   logic [8:0] rfg_ff, rfg_in;
   logic       int_en_ff, int_en_in;
   logic       wide_en_ff, wide_en_in;
   logic       slow_en_ff, slow_en_in;
   logic       csr_write;

   // latched tick
   logic signed [14:0] meas_ff, targ_ff;
   logic [13:0]        kp_ff;
   logic [14:0]        kd_ff;
   logic signed [16:0] wz_ff;
   logic [13:0]        vxa_ff, vya_ff, vxa_in, vya_in;

   // controller history
   logic signed [14:0]               prev_err_ff, prev_err_in;
   logic signed [15:0]               prev_diff_ff, prev_diff_in;
   logic signed [INTEGRAL_WIDTH-1:0] int_ff, int_in;

   // datapath
   logic signed [14:0]    e_ff, e_in;
   logic signed [16:0]    dsum_ff, dsum_in;
   logic                  wide_ff, wide_in;
   logic signed [TOT_W-1:0] acc_ff, acc_in;
   logic [SPD_W-1:0]      spd_ff, spd_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [14:0]    rsp_cmd_ff, rsp_cmd_in;

   logic signed [15:0]        diff, wrapped, d_val;
   logic signed [14:0]        e_val, e_neg;
   logic [13:0]               ae_val;
   logic                      in_window;
   logic signed [INT_EXT_W-1:0] isum;
   logic signed [INTEGRAL_WIDTH-1:0] isat;

   logic signed [MA_W-1:0]  mul_a;
   logic [MB_W-1:0]         mul_b;
   logic signed [MP_W-1:0]  prod;
   logic signed [TOT_W-1:0] prod_t;

   logic signed [31:0]      lim32;
   logic signed [TOT_W-1:0] lim_pos, lim_neg, clamped;
   logic signed [31:0]      rnd;

   assign uc         = ucode_rom(step_ff);
   assign run        = (state_ff == SEQ_RUN);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign csr_write  = psel && penable && pwrite && pready;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (req_accept) begin
               state_in = SEQ_RUN;
               step_in  = STEP_ERR;
            end
         end
         SEQ_RUN: begin
            case (uc.jmp)
               JMP_NEXT: begin
                  step_in = step_ff + 3'd1;
               end
               JMP_IF_INT_ZERO: begin
                  step_in = (int_ff == '0) ? uc.target : step_ff + 3'd1;
               end
               JMP_END: begin
                  // a new tick may start in the same cycle the result is loaded
                  if (out_free) begin
                     state_in = req_accept ? SEQ_RUN : SEQ_IDLE;
                     step_in  = STEP_ERR;
                  end
               end
               default: begin
                  state_in = SEQ_IDLE;
                  step_in  = STEP_ERR;
               end
            endcase
         end
         default: begin
            state_in = SEQ_IDLE;
            step_in  = STEP_ERR;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            req_stall = 1'b0;
         end
         SEQ_RUN: begin
            req_stall = !(uc.jmp == JMP_END && out_free);
            load_out  = uc.out_en && out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_comb begin
      igain_in   = igain_ff;
      rfg_in     = rfg_ff;
      int_en_in  = int_en_ff;
      wide_en_in = wide_en_ff;
      slow_en_in = slow_en_ff;
      if (csr_write) begin
         case (paddr[4:2])
            CSR_IGAIN:   igain_in   = pwdata[7:0];
            CSR_RFGAIN:  rfg_in     = pwdata[8:0];
            CSR_INT_EN:  int_en_in  = pwdata[0];
            CSR_WIDE_EN: wide_en_in = pwdata[0];
            CSR_SLOW_EN: slow_en_in = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         CSR_IGAIN:   prdata = 32'(igain_ff);
         CSR_RFGAIN:  prdata = 32'(rfg_ff);
         CSR_INT_EN:  prdata = 32'(int_en_ff);
         CSR_WIDE_EN: prdata = 32'(wide_en_ff);
         CSR_SLOW_EN: prdata = 32'(slow_en_ff);
         default:     prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   // ---------------------------------------------------------------- error step
   always_comb begin
      wrapped = 16'(targ_ff) - 16'(meas_ff);
      diff    = wrapped;
      if (diff > ERR_HALF_TURN) begin
         wrapped = diff - ERR_FULL_TURN;
      end else if (diff < ERR_NEG_HALF) begin
         wrapped = diff + ERR_FULL_TURN;
      end
      e_val  = wrapped[14:0];
      e_neg  = -e_val;
      ae_val = e_val[14] ? e_neg[13:0] : e_val[13:0];
      d_val  = 16'(e_val) - 16'(prev_err_ff);

      in_window = int_en_ff && (ae_val >= INT_LOW_MIN) && (ae_val < INT_HIGH_LIM);
      isum      = INT_EXT_W'(int_ff) + INT_EXT_W'(e_val);
      // saturate at the signed limits of the integral width
      if (isum[INTEGRAL_WIDTH] != isum[INTEGRAL_WIDTH-1]) begin
         isat = isum[INTEGRAL_WIDTH] ? {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}}
                                     : {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
      end else begin
         isat = isum[INTEGRAL_WIDTH-1:0];
      end

      e_in         = e_ff;
      dsum_in      = dsum_ff;
      wide_in      = wide_ff;
      prev_err_in  = prev_err_ff;
      prev_diff_in = prev_diff_ff;
      int_in       = int_ff;
      if (run && uc.err_en) begin
         e_in         = e_val;
         dsum_in      = 17'(d_val) + 17'(prev_diff_ff);
         wide_in      = ae_val > WIDE_ERR;
         prev_err_in  = e_val;
         prev_diff_in = d_val;
         int_in       = in_window ? isat : '0;
      end
   end

   // ---------------------------------------------------------------- multiplier
   always_comb begin
      case (uc.a_sel)
         A_ERR:   mul_a = MA_W'(e_ff);
         A_DSUM:  mul_a = MA_W'(dsum_ff);
         A_INT:   mul_a = MA_W'(int_ff);
         A_PID:   mul_a = $signed(acc_ff[PID_W-1:0]);
         A_RATE:  mul_a = MA_W'(wz_ff);
         A_SPDX:  mul_a = $signed(MA_W'(vxa_ff));
         A_SPDY:  mul_a = $signed(MA_W'(vya_ff));
         default: mul_a = '0;
      endcase
      case (uc.b_sel)
         B_KP2:   mul_b = {kp_ff, 1'b0};
         B_KD:    mul_b = kd_ff;
         B_KI2:   mul_b = MB_W'({igain_ff, 1'b0});
         B_GSC:   mul_b = MB_W'(10'(rfg_ff) + 10'd256);
         B_GAIN:  mul_b = MB_W'(rfg_ff);
         B_SPDX:  mul_b = MB_W'(vxa_ff);
         B_SPDY:  mul_b = MB_W'(vya_ff);
         default: mul_b = '0;
      endcase
   end

   assign prod   = MP_W'(mul_a) * MP_W'($signed({1'b0, mul_b}));
   assign prod_t = prod[TOT_W-1:0];

   always_comb begin
      acc_in = acc_ff;
      spd_in = spd_ff;
      if (run) begin
         case (uc.acc_op)
            ACC_HOLD:    acc_in = acc_ff;
            ACC_LOAD:    acc_in = prod_t;
            ACC_ADD:     acc_in = acc_ff + prod_t;
            ACC_SUB_SH9: acc_in = acc_ff - (prod_t <<< 9);
            default:     acc_in = acc_ff;
         endcase
         case (uc.spd_op)
            SPD_HOLD: spd_in = spd_ff;
            SPD_LOAD: spd_in = prod[SPD_W-1:0];
            SPD_ADD:  spd_in = spd_ff + prod[SPD_W-1:0];
            default:  spd_in = spd_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------- clamp, round
   always_comb begin
      // nested clamps reduce to the tightest active limit
      if (slow_en_ff && (spd_ff < SLOW_SPEED_SQ)) begin
         lim32 = LIM_SLOW_SC;
      end else if (wide_en_ff && wide_ff) begin
         lim32 = LIM_WIDE_SC;
      end else begin
         lim32 = LIM_MAIN_SC;
      end
      lim_pos = TOT_W'(lim32);
      lim_neg = -lim_pos;
      if (acc_ff > lim_pos) begin
         clamped = lim_pos;
      end else if (acc_ff < lim_neg) begin
         clamped = lim_neg;
      end else begin
         clamped = acc_ff;
      end
      // round half up to whole output units
      rnd = $signed(clamped[31:0]) + ROUND_HALF;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cmd_in   = rsp_cmd_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_cmd_in   = rnd[31:17];
      end
   end

   assign vxa_in = req_speed_x[13] ? 14'(-req_speed_x) : req_speed_x;
   assign vya_in = req_speed_y[13] ? 14'(-req_speed_y) : req_speed_y;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rate_command = rsp_cmd_ff;

   // ---------------------------------------------------------------- flops
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         step_ff      <= STEP_ERR;
         igain_ff     <= IGAIN_RESET;
         rfg_ff       <= '0;
         int_en_ff    <= 1'b0;
         wide_en_ff   <= 1'b0;
         slow_en_ff   <= 1'b1;
         prev_err_ff  <= '0;
         prev_diff_ff <= '0;
         int_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         igain_ff     <= igain_in;
         rfg_ff       <= rfg_in;
         int_en_ff    <= int_en_in;
         wide_en_ff   <= wide_en_in;
         slow_en_ff   <= slow_en_in;
         prev_err_ff  <= prev_err_in;
         prev_diff_ff <= prev_diff_in;
         int_ff       <= int_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         meas_ff <= req_measured_angle;
         targ_ff <= req_target_angle;
         kp_ff   <= req_prop_gain;
         kd_ff   <= req_deriv_gain;
         wz_ff   <= req_measured_rate;
         vxa_ff  <= vxa_in;
         vya_ff  <= vya_in;
      end
      e_ff       <= e_in;
      dsum_ff    <= dsum_in;
      wide_ff    <= wide_in;
      acc_ff     <= acc_in;
      spd_ff     <= spd_in;
      rsp_cmd_ff <= rsp_cmd_in;
   end

   // ---------------------------------------------------------------- assertions
   a_out_from_last_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == SEQ_RUN && step_ff == STEP_OUT))
      else $error("result loaded outside the output step");

   a_run_progresses: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_RUN && step_ff != STEP_OUT) |=> state_ff == SEQ_RUN)
      else $error("sequencer left a tick before the output step");

   a_integral_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_RUN && step_ff == STEP_ERR && !int_en_ff) |=> int_ff == '0)
      else $error("integral not cleared with integration disabled");

   a_output_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_cmd_ff <= 15'sd15040 && rsp_cmd_ff >= -15'sd15040))
      else $error("rate command beyond the main limit");

endmodule
